>>> sv/dba_pkg.sv
package dba_pkg;

    // Fixed-point widths: Q8.16 state and unsigned Q0.16 time step.
    localparam int Q_W    = 24;
    localparam int DT_W   = 16;
    localparam int FRAC_W = 16;
    localparam int CNT_W  = 3;
    localparam int PROD_W = Q_W + DT_W;
    localparam int NUM_AXES = 2;

    // Number of bounces after which an axis comes to rest.
    localparam logic [CNT_W-1:0] BOUNCE_LIMIT = CNT_W'(5);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 1'b1;

    // Request types.
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Axis selects.
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Recorded direction of travel.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RESTART,
        OP_MUL_ACC,
        OP_ADD_VEL,
        OP_MUL_VEL,
        OP_ADD_POS,
        OP_BOUNCE
    } dba_op_t;

    // Command bundle from controller to datapath.
    typedef struct packed {
        logic    capture;
        dba_op_t op;
        logic    axis;
        logic    load_out;
    } dba_cmd_t;

    // Saturate a 25-bit signed value to 24 bits.
    function automatic logic signed [Q_W-1:0] sat_25(input logic signed [Q_W:0] v);
        logic signed [Q_W-1:0] r;
        if (v[Q_W] != v[Q_W-1])
        begin
            r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end
        else
        begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // Saturate a 27-bit signed value to 24 bits.
    function automatic logic signed [Q_W-1:0] sat_27(input logic signed [Q_W+2:0] v);
        logic signed [Q_W-1:0] r;
        if (!v[Q_W+2] && (v[Q_W+1:Q_W-1] != 3'b000))
        begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        else if (v[Q_W+2] && (v[Q_W+1:Q_W-1] != 3'b111))
        begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/dba_ctrl.sv
module dba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               req_type,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    output dba_pkg::dba_cmd_t  cmd
);
    import dba_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESTART,
        ST_MUL_ACC,
        ST_ADD_VEL,
        ST_MUL_VEL,
        ST_ADD_POS,
        ST_BOUNCE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequencing of one request and the command for the current step.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cmd.capture    = 1'b0;
        cmd.op         = OP_NONE;
        cmd.axis       = axis_reg;
        cmd.load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = AXIS_X;
                    state_next  = (req_type == REQ_RESTART) ? ST_RESTART : ST_MUL_ACC;
                end
            end
            ST_RESTART:
            begin
                cmd.op     = OP_RESTART;
                state_next = ST_DONE;
            end
            ST_MUL_ACC:
            begin
                cmd.op     = OP_MUL_ACC;
                state_next = ST_ADD_VEL;
            end
            ST_ADD_VEL:
            begin
                cmd.op     = OP_ADD_VEL;
                state_next = ST_MUL_VEL;
            end
            ST_MUL_VEL:
            begin
                cmd.op     = OP_MUL_VEL;
                state_next = ST_ADD_POS;
            end
            ST_ADD_POS:
            begin
                cmd.op     = OP_ADD_POS;
                state_next = ST_BOUNCE;
            end
            ST_BOUNCE:
            begin
                cmd.op = OP_BOUNCE;
                if (axis_reg == AXIS_X)
                begin
                    axis_next  = AXIS_Y;
                    state_next = ST_MUL_ACC;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The result stays valid until the receiver takes it.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/dba_datapath.sv
module dba_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dba_pkg::dba_cmd_t                   cmd,
    input  logic [dba_pkg::DT_W-1:0]            time_step,
    input  logic                                cfg_we,
    input  logic [dba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dba_pkg::Q_W-1:0]             cfg_data,
    output logic signed [dba_pkg::Q_W-1:0]      position_x,
    output logic signed [dba_pkg::Q_W-1:0]      position_y,
    output logic                                settled_x,
    output logic                                settled_y
);
    import dba_pkg::*;

    // Configuration and per-axis motion state.
    logic signed [Q_W-1:0]  offset_reg [NUM_AXES];
    logic signed [Q_W-1:0]  pos_reg    [NUM_AXES];
    logic signed [Q_W-1:0]  vel_reg    [NUM_AXES];
    logic signed [Q_W-1:0]  acc_reg    [NUM_AXES];
    logic [1:0]             dir_reg    [NUM_AXES];
    logic [CNT_W-1:0]       bnc_reg    [NUM_AXES];

    // Request payload and shared multiplier result.
    logic [DT_W-1:0]        dt_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Result payload.
    logic signed [Q_W-1:0]  pos_x_out_reg;
    logic signed [Q_W-1:0]  pos_y_out_reg;
    logic                   set_x_out_reg;
    logic                   set_y_out_reg;

    logic signed [Q_W-1:0]    mul_a;
    logic signed [PROD_W:0]   mul_full;
    logic signed [Q_W-1:0]    scaled;
    logic signed [Q_W-1:0]    add_a;
    logic signed [Q_W-1:0]    add_sum;
    logic signed [Q_W-1:0]    cur_pos;
    logic signed [Q_W-1:0]    cur_vel;
    logic [CNT_W-1:0]         cur_bnc;
    logic                     overshoot;
    logic signed [Q_W-1:0]    bnc_acc;
    logic signed [Q_W-1:0]    bnc_neg;
    logic signed [Q_W-1:0]    bnc_vel;
    logic [CNT_W-1:0]         bnc_inc;
    logic                     bnc_stop;
    logic signed [Q_W-1:0]    rst_vel [NUM_AXES];
    logic [1:0]               rst_dir [NUM_AXES];

    assign cur_pos = pos_reg[cmd.axis];
    assign cur_vel = vel_reg[cmd.axis];
    assign cur_bnc = bnc_reg[cmd.axis];

    // Shared multiplier: state value times the unsigned time step.
    assign mul_a    = (cmd.op == OP_MUL_ACC) ? acc_reg[cmd.axis] : cur_vel;
    assign mul_full = mul_a * $signed({1'b0, dt_reg});

    // Floor shift of the product; it always fits the Q8.16 range.
    assign scaled  = prod_reg[PROD_W-1:FRAC_W];
    assign add_a   = (cmd.op == OP_ADD_VEL) ? cur_vel : cur_pos;
    assign add_sum = sat_25({add_a[Q_W-1], add_a} + {scaled[Q_W-1], scaled});

    // Overshoot test and damped rebound values.
    assign overshoot = (cur_bnc < BOUNCE_LIMIT) &&
                       (((dir_reg[cmd.axis] == DIR_NEG) && cur_pos[Q_W-1]) ||
                        ((dir_reg[cmd.axis] == DIR_POS) && !cur_pos[Q_W-1] &&
                         (cur_pos != '0)));
    assign bnc_acc  = sat_25({cur_vel, 1'b0});
    assign bnc_neg  = sat_25(-{cur_vel[Q_W-1], cur_vel});
    assign bnc_vel  = bnc_neg >>> 2;
    assign bnc_inc  = cur_bnc + CNT_W'(1);
    assign bnc_stop = (bnc_inc >= BOUNCE_LIMIT);

    // Restart values: velocity is minus five times the offset.
    always_comb
    begin
        logic signed [Q_W+2:0] off_ext;
        logic signed [Q_W+2:0] times5;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            off_ext = {{3{offset_reg[i][Q_W-1]}}, offset_reg[i]};
            times5  = (off_ext <<< 2) + off_ext;
            rst_vel[i] = sat_27(-times5);
            if (rst_vel[i] == '0)
            begin
                rst_dir[i] = DIR_NONE;
            end
            else if (rst_vel[i][Q_W-1])
            begin
                rst_dir[i] = DIR_NEG;
            end
            else
            begin
                rst_dir[i] = DIR_POS;
            end
        end
    end

    // Configuration and motion state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                offset_reg[i] <= '0;
                pos_reg[i]    <= '0;
                vel_reg[i]    <= '0;
                acc_reg[i]    <= '0;
                dir_reg[i]    <= DIR_NONE;
                bnc_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OFFSET_X: offset_reg[AXIS_X] <= cfg_data;
                    CFG_OFFSET_Y: offset_reg[AXIS_Y] <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_RESTART:
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        pos_reg[i] <= offset_reg[i];
                        vel_reg[i] <= rst_vel[i];
                        acc_reg[i] <= '0;
                        dir_reg[i] <= rst_dir[i];
                        bnc_reg[i] <= '0;
                    end
                end
                OP_ADD_VEL:
                begin
                    vel_reg[cmd.axis] <= add_sum;
                end
                OP_ADD_POS:
                begin
                    pos_reg[cmd.axis] <= add_sum;
                end
                OP_BOUNCE:
                begin
                    if (overshoot)
                    begin
                        pos_reg[cmd.axis] <= '0;
                        bnc_reg[cmd.axis] <= bnc_inc;
                        acc_reg[cmd.axis] <= bnc_stop ? '0 : bnc_acc;
                        vel_reg[cmd.axis] <= bnc_stop ? '0 : bnc_vel;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers: time step, product and result.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dt_reg <= time_step;
        end
        if ((cmd.op == OP_MUL_ACC) || (cmd.op == OP_MUL_VEL))
        begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
        if (cmd.load_out)
        begin
            pos_x_out_reg <= pos_reg[AXIS_X];
            pos_y_out_reg <= pos_reg[AXIS_Y];
            set_x_out_reg <= (bnc_reg[AXIS_X] >= BOUNCE_LIMIT);
            set_y_out_reg <= (bnc_reg[AXIS_Y] >= BOUNCE_LIMIT);
        end
    end

    assign position_x = pos_x_out_reg;
    assign position_y = pos_y_out_reg;
    assign settled_x  = set_x_out_reg;
    assign settled_y  = set_y_out_reg;

endmodule

>>> sv/damped_bounce_animator_core.sv
// Two-axis damped return-to-origin animator.
// Input channel: in_valid / in_stall with req_type and time_step. A request is
// taken at a clock edge with in_valid high and in_stall low. A restart request
// loads each axis from its offset register; a tick request advances the motion
// by time_step seconds (unsigned Q0.16).
// Output channel: out_valid / out_stall with position_x, position_y (signed
// Q8.16) and settled_x, settled_y. Every request yields exactly one result.
// Offsets are written through cfg_we, cfg_index and cfg_data while idle; they
// take effect at the next restart.
// Sequencing: a tick runs five steps per axis on one shared multiplier and
// adder, axes in turn; a restart loads both axes together.
// One request is in flight at a time, so a new request is not taken until
// the previous one has finished. The finished result sits in an output register,
// so the block takes the next request while the previous result still waits.
// When out_stall holds a result, a later request finishes its work and then
// waits until the output register is free. Reset clears all motion state and
// the offsets to zero and leaves no result pending.
module damped_bounce_animator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [dba_pkg::DT_W-1:0]            time_step,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dba_pkg::Q_W-1:0]      position_x,
    output logic signed [dba_pkg::Q_W-1:0]      position_y,
    output logic                                settled_x,
    output logic                                settled_y,
    input  logic                                cfg_we,
    input  logic [dba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dba_pkg::Q_W-1:0]             cfg_data
);
    import dba_pkg::*;

    dba_cmd_t cmd;

    // Request sequencing and output handshake.
    dba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Arithmetic, motion state and result registers.
    dba_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .time_step  (time_step),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .position_x (position_x),
        .position_y (position_y),
        .settled_x  (settled_x),
        .settled_y  (settled_y)
    );

endmodule

>>> bench/tb_damped_bounce_animator_core.sv
module tb_damped_bounce_animator_core;

    timeunit 1ns;
    timeprecision 1ps;

    import dba_pkg::*;

    localparam int RUN_ITEMS   = 1650;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;

    // Shadow of the animator: offsets, motion state per axis and the frames still owed.
    class bounce_scoreboard;

        typedef struct {
            logic signed [Q_W-1:0] pos_x;
            logic signed [Q_W-1:0] pos_y;
            logic                  settled_x;
            logic                  settled_y;
        } frame_t;

        longint     offset  [NUM_AXES];
        longint     pos     [NUM_AXES];
        longint     vel     [NUM_AXES];
        longint     acc     [NUM_AXES];
        logic [1:0] dir     [NUM_AXES];
        int         bounces [NUM_AXES];
        frame_t     frames_due [$];
        int         errors;

        function new();
            for (int i = 0; i < NUM_AXES; i++)
            begin
                offset[i]  = 0;
                pos[i]     = 0;
                vel[i]     = 0;
                acc[i]     = 0;
                dir[i]     = DIR_NONE;
                bounces[i] = 0;
            end
            errors = 0;
        endfunction

        // Clamp to the signed Q8.16 range.
        static function longint sat_q(longint v);
            if (v > 64'sd8388607)
            begin
                return 64'sd8388607;
            end
            if (v < -64'sd8388608)
            begin
                return -64'sd8388608;
            end
            return v;
        endfunction

        // Q8.16 times Q0.16, floored back to Q8.16.
        static function longint scale_by_step(longint a, logic [DT_W-1:0] dt);
            longint prod;
            prod = a * longint'(dt);
            return sat_q(prod >>> FRAC_W);
        endfunction

        function void write_offset(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
            offset[idx] = longint'(signed'(data));
        endfunction

        // Advance the shadow state by one request and queue the frame it produces.
        function void note_request(logic rt, logic [DT_W-1:0] dt);
            frame_t f;
            longint p;
            longint v;
            bit     over;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (rt == REQ_RESTART)
                begin
                    pos[i]     = offset[i];
                    vel[i]     = sat_q(-offset[i] * 5);
                    acc[i]     = 0;
                    bounces[i] = 0;
                    dir[i]     = (vel[i] > 0) ? DIR_POS : ((vel[i] < 0) ? DIR_NEG : DIR_NONE);
                end
                else
                begin
                    v = sat_q(vel[i] + scale_by_step(acc[i], dt));
                    p = sat_q(pos[i] + scale_by_step(v, dt));
                    if (bounces[i] < BOUNCE_LIMIT)
                    begin
                        over = (dir[i] == DIR_NEG && p < 0) || (dir[i] == DIR_POS && p > 0);
                        if (over)
                        begin
                            // Bounce: reverse and damp, pull back with twice the speed.
                            acc[i] = sat_q(v * 2);
                            v      = sat_q(-v) >>> 2;
                            p      = 0;
                            bounces[i]++;
                            if (bounces[i] >= BOUNCE_LIMIT)
                            begin
                                acc[i] = 0;
                                v      = 0;
                            end
                        end
                    end
                    vel[i] = v;
                    pos[i] = p;
                end
            end
            f.pos_x     = pos[0][Q_W-1:0];
            f.pos_y     = pos[1][Q_W-1:0];
            f.settled_x = (bounces[0] >= BOUNCE_LIMIT);
            f.settled_y = (bounces[1] >= BOUNCE_LIMIT);
            frames_due.push_back(f);
        endfunction

        // Compare one delivered frame against the oldest one owed.
        function void check_result(logic signed [Q_W-1:0] px, logic signed [Q_W-1:0] py,
                                   logic sx, logic sy);
            frame_t f;
            if (frames_due.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            f = frames_due.pop_front();
            if (px !== f.pos_x)
            begin
                $error("position_x: expected %0d, got %0d", f.pos_x, px);
                errors++;
            end
            if (py !== f.pos_y)
            begin
                $error("position_y: expected %0d, got %0d", f.pos_y, py);
                errors++;
            end
            if (sx !== f.settled_x)
            begin
                $error("settled_x: expected %0b, got %0b", f.settled_x, sx);
                errors++;
            end
            if (sy !== f.settled_y)
            begin
                $error("settled_y: expected %0b, got %0b", f.settled_y, sy);
                errors++;
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic                         req_type  = REQ_TICK;
    logic [DT_W-1:0]              time_step = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [Q_W-1:0]        position_x;
    logic signed [Q_W-1:0]        position_y;
    logic                         settled_x;
    logic                         settled_y;
    logic                         cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = CFG_OFFSET_X;
    logic [Q_W-1:0]               cfg_data  = '0;

    bounce_scoreboard sb = new();

    int  items_sent      = 0;
    int  burst_left      = 0;
    int  cycle_count     = 0;
    bit  hold_off_wanted = 1'b0;

    damped_bounce_animator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .time_step  (time_step),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position_x (position_x),
        .position_y (position_y),
        .settled_x  (settled_x),
        .settled_y  (settled_y),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("damped_bounce_animator_core test failed");
            $finish;
        end
    end

    // Both handshakes are observed here: results are checked, requests are predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result(position_x, position_y, settled_x, settled_y);
            end
            if (in_valid && !in_stall)
            begin
                sb.note_request(req_type, time_step);
            end
        end
    end

    // Receiver back-pressure: segments of free flow, light and heavy stalling,
    // and one long hold-off when asked for.
    initial
    begin
        int seg_len;
        int mode;
        forever
        begin
            if (hold_off_wanted)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_wanted = 1'b0;
            end
            else
            begin
                seg_len = $urandom_range(20, 200);
                mode    = $urandom_range(0, 2);
                repeat (seg_len)
                begin
                    // A requested hold-off starts at once, while the sender is busy.
                    if (hold_off_wanted)
                    begin
                        break;
                    end
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Offer one request, in bursts with random gaps, and return at its acceptance edge.
    task automatic send_request(logic rt, logic [DT_W-1:0] dt);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid  <= 1'b1;
        req_type  <= rt;
        time_step <= dt;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        burst_left--;
        items_sent++;
    endtask

    // Hold the sender off until every owed frame has been delivered.
    // The pending check is made only once the last accepted request has already been noted.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_offset_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_offset(idx, data);
        @(posedge clk);
    endtask

    function automatic logic [Q_W-1:0] pick_offset();
        logic [Q_W-1:0] mag;
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return '0;
            3:       return Q_W'($urandom);
            default:
            begin
                mag = Q_W'($urandom_range(16, 24'h080000));
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_time_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return DT_W'($urandom);
            default: return DT_W'($urandom_range(1, 16'h2000));
        endcase
    endfunction

    // A restart followed by a run of ticks.
    task automatic run_glide(int n_ticks);
        send_request(REQ_RESTART, DT_W'($urandom));
        repeat (n_ticks) send_request(REQ_TICK, pick_time_step());
    endtask

    initial
    begin
        int phase;
        int n_glides;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ticks before any restart leave everything at rest.
        send_request(REQ_TICK, 16'hFFFF);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_TICK, DT_W'($urandom));
        wait_drained();

        // Extreme offsets: the launch velocity saturates on both axes.
        write_offset_reg(CFG_OFFSET_X, 24'h7FFFFF);
        write_offset_reg(CFG_OFFSET_Y, 24'h800000);
        send_request(REQ_RESTART, 16'hFFFF);
        repeat (3) send_request(REQ_TICK, 16'hFFFF);
        // A restart does not look at the time step.
        send_request(REQ_RESTART, 16'h0000);
        wait_drained();

        // New offsets written mid-flight only apply at the next restart;
        // a zero offset never bounces, and the other axis settles.
        write_offset_reg(CFG_OFFSET_X, 24'h000000);
        write_offset_reg(CFG_OFFSET_Y, 24'hFF0000);
        repeat (2) send_request(REQ_TICK, 16'h4000);
        send_request(REQ_RESTART, 16'h1234);
        repeat (7) send_request(REQ_TICK, 16'hFFFF);
        wait_drained();

        // Horizontal axis runs to rest while the vertical one, restarted from the same offset, settles again.
        write_offset_reg(CFG_OFFSET_X, 24'h010000);
        send_request(REQ_RESTART, 16'hFFFF);
        repeat (6) send_request(REQ_TICK, 16'hFFFF);
        wait_drained();

        // Random phases: new offsets while idle, then mostly well-formed glides.
        phase = 0;
        while (items_sent < RUN_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:       write_offset_reg(CFG_OFFSET_X, pick_offset());
                1:       write_offset_reg(CFG_OFFSET_Y, pick_offset());
                default:
                begin
                    write_offset_reg(CFG_OFFSET_X, pick_offset());
                    write_offset_reg(CFG_OFFSET_Y, pick_offset());
                end
            endcase
            // Let the receiver hold off once while the sender keeps pushing.
            if (phase == 2)
            begin
                hold_off_wanted = 1'b1;
            end
            // Sometimes the previous motion carries on under the new offsets.
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 6)) send_request(REQ_TICK, pick_time_step());
            end
            n_glides = $urandom_range(1, 4);
            repeat (n_glides)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(3, 15))
                    begin
                        send_request(logic'($urandom_range(0, 1)), DT_W'($urandom));
                    end
                end
                else
                begin
                    run_glide($urandom_range(4, 40));
                end
            end
            wait_drained();
            phase++;
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("damped_bounce_animator_core test passed");
        end
        else
        begin
            $display("damped_bounce_animator_core test failed");
        end
        $finish;
    end

endmodule
